// ===== rtl/core/hft_pkg.sv =====
// ----------------------------------------------------------------------------
// hft_pkg
// Constants shared by the half-face transmissibility pipeline.
// ----------------------------------------------------------------------------
package hft_pkg;
	localparam int FRAC_BITS     = 10;
	localparam int OUT_FRAC_BITS = 24;
	localparam int OUT_BITS      = 48;
	localparam int VEC_BITS      = 63;
endpackage

// ===== rtl/core/hft_if.sv =====
// ----------------------------------------------------------------------------
// hft_in_if / hft_out_if
// Valid/ready channels for half-face items and results.
// ----------------------------------------------------------------------------
interface hft_in_if;
	logic        valid;
	logic        ready;
	logic [62:0] perm_col0;
	logic [62:0] perm_col1;
	logic [62:0] perm_col2;
	logic [62:0] normal_vec;
	logic [62:0] face_center;
	logic [62:0] cell_center;
	logic        is_first_cell;
	modport source (output valid, perm_col0, perm_col1, perm_col2, normal_vec,
		face_center, cell_center, is_first_cell, input ready);
	modport sink (input valid, perm_col0, perm_col1, perm_col2, normal_vec,
		face_center, cell_center, is_first_cell, output ready);
endinterface

interface hft_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] half_trans;
	logic        zero_distance;
	logic        saturated;
	modport source (output valid, half_trans, zero_distance, saturated, input ready);
	modport sink (input valid, half_trans, zero_distance, saturated, output ready);
endinterface

// ===== rtl/core/half_face_transmissibility.sv =====
// ----------------------------------------------------------------------------
// half_face_transmissibility
// Two-point flux half transmissibility |d.(K n)| / (d.d) in Q24.24.
// ----------------------------------------------------------------------------
// One half-face enters per cycle; its result passes the product, row-sum,
// d.(K n) product and numerator-magnitude registers, then the pipelined
// restoring divider at four quotient bits per stage (21 stages for the
// 82-bit numerator), then the output register. Throughput is one item per
// cycle; a stall on the output freezes the whole pipeline and loses nothing.
// A zero distance gives half_trans 0 with zero_distance set; a quotient
// beyond 48 bits gives the maximum with saturated set.
module half_face_transmissibility
	import hft_pkg::*;
#(
	parameter int DIMENSIONS = 3,
	parameter int COMP_BITS  = 21
) (
	input logic      clk,
	input logic      arst_n,
	hft_in_if.sink   in_ch,
	hft_out_if.source out_ch
);
	localparam int PROD_BITS = 2 * COMP_BITS;
	localparam int KN_BITS   = PROD_BITS + 2;
	localparam int D_BITS    = COMP_BITS + 1;
	localparam int DEN_BITS  = 2 * D_BITS + 1;
	localparam int NP_BITS   = KN_BITS + D_BITS;
	localparam int NUM_BITS  = NP_BITS + 2;
	localparam int SH        = OUT_FRAC_BITS - FRAC_BITS;
	localparam int DIVN_BITS = NUM_BITS + SH;

	typedef logic signed [COMP_BITS-1:0] comp_t;

	logic en;
	logic out_full_q;
	assign en = !out_full_q || out_ch.ready;
	assign in_ch.ready = en;

	function automatic comp_t get_c(input logic [VEC_BITS-1:0] w, input int i);
		get_c = comp_t'(w[i*COMP_BITS +: COMP_BITS]);
	endfunction

	// Stage 1: K n products and centroid offsets.
	logic                         v_s1;
	logic signed [PROD_BITS-1:0]  p_s1 [3][3];
	logic signed [D_BITS-1:0]     d_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					logic [VEC_BITS-1:0] col;
					col = (c == 0) ? in_ch.perm_col0 :
						(c == 1) ? in_ch.perm_col1 : in_ch.perm_col2;
					if (r < DIMENSIONS && c < DIMENSIONS)
						p_s1[r][c] <= PROD_BITS'(get_c(col, r) * get_c(in_ch.normal_vec, c));
					else
						p_s1[r][c] <= '0;
				end
				if (r < DIMENSIONS)
					d_s1[r] <= D_BITS'(get_c(in_ch.face_center, r))
						- D_BITS'(get_c(in_ch.cell_center, r));
				else
					d_s1[r] <= '0;
			end
		end
	end

	// Stage 2: row sums and squared offsets.
	logic                        v_s2;
	logic signed [KN_BITS-1:0]   kn_s2 [3];
	logic signed [D_BITS-1:0]    d_s2  [3];
	logic [2*D_BITS-1:0]         sq_s2 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				kn_s2[r] <= KN_BITS'(p_s1[r][0]) + KN_BITS'(p_s1[r][1])
					+ KN_BITS'(p_s1[r][2]);
				d_s2[r]  <= d_s1[r];
				sq_s2[r] <= (2*D_BITS)'(d_s1[r] * d_s1[r]);
			end
		end
	end

	// Stage 3: d times Kn products and the denominator.
	logic                        v_s3;
	logic signed [NP_BITS-1:0]   np_s3 [3];
	logic [DEN_BITS-1:0]         den_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				np_s3[r] <= NP_BITS'(NP_BITS'(d_s2[r]) * NP_BITS'(kn_s2[r]));
			den_s3 <= DEN_BITS'(sq_s2[0]) + DEN_BITS'(sq_s2[1]) + DEN_BITS'(sq_s2[2]);
		end
	end

	// Stage 4: numerator magnitude, aligned to the output fraction.
	logic                   v_s4;
	logic [DIVN_BITS-1:0]   num_s4;
	logic [DEN_BITS-1:0]    den_s4;
	logic                   zero_s4;
	logic signed [NUM_BITS-1:0] sum_c;
	logic [NUM_BITS-1:0]    mag_c;
	always_comb begin
		sum_c = NUM_BITS'(np_s3[0]) + NUM_BITS'(np_s3[1]) + NUM_BITS'(np_s3[2]);
		mag_c = sum_c[NUM_BITS-1] ? NUM_BITS'(-sum_c) : NUM_BITS'(sum_c);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= {mag_c, {SH{1'b0}}};
			den_s4  <= den_s3;
			zero_s4 <= (den_s3 == '0);
		end
	end

	// Quotient.
	logic                 dv_valid, dv_zero;
	logic [DIVN_BITS-1:0] dv_quot;
	hft_divider #(
		.NUM_BITS(DIVN_BITS), .DEN_BITS(DEN_BITS), .BITS_PER_STAGE(4)
	) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .in_num(num_s4), .in_den(den_s4), .in_zero(zero_s4),
		.out_valid(dv_valid), .out_quot(dv_quot), .out_zero(dv_zero)
	);

	// Output register with saturation.
	logic        sat_c;
	assign sat_c = (dv_quot[DIVN_BITS-1:OUT_BITS] != '0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_full_q <= 1'b0;
		else if (en) out_full_q <= dv_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.zero_distance <= dv_zero;
			out_ch.saturated     <= !dv_zero && sat_c;
			out_ch.half_trans    <= dv_zero ? '0 :
				sat_c ? {OUT_BITS{1'b1}} : dv_quot[OUT_BITS-1:0];
		end
	end
	assign out_ch.valid = out_full_q;
endmodule

// ===== rtl/core/hft_divider.sv =====
// ----------------------------------------------------------------------------
// hft_divider
// Pipelined restoring divider, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module hft_divider
	import hft_pkg::*;
#(
	parameter int NUM_BITS = 96,
	parameter int DEN_BITS = 45,
	parameter int BITS_PER_STAGE = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [NUM_BITS-1:0] in_num,
	input  logic [DEN_BITS-1:0] in_den,
	input  logic                in_zero,
	output logic                out_valid,
	output logic [NUM_BITS-1:0] out_quot,
	output logic                out_zero
);
	localparam int STAGES = (NUM_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam int REM_BITS = DEN_BITS + 1;

	logic                v_q   [1:STAGES];
	logic                z_q   [1:STAGES];
	logic [NUM_BITS-1:0] n_q   [1:STAGES];
	logic [DEN_BITS-1:0] d_q   [1:STAGES];
	logic [REM_BITS-1:0] r_q   [1:STAGES];

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		logic                v_p;
		logic                z_p;
		logic [NUM_BITS-1:0] n_p;
		logic [DEN_BITS-1:0] d_p;
		logic [REM_BITS-1:0] r_p;
		logic [NUM_BITS-1:0] n_c;
		logic [REM_BITS-1:0] r_c;
		// The first stage takes the ports, every later one the stage before it.
		if (s == 0) begin : g_head
			assign v_p = in_valid;
			assign z_p = in_zero;
			assign n_p = in_num;
			assign d_p = in_den;
			assign r_p = '0;
		end else begin : g_body
			assign v_p = v_q[s];
			assign z_p = z_q[s];
			assign n_p = n_q[s];
			assign d_p = d_q[s];
			assign r_p = r_q[s];
		end
		// Shift in one numerator bit per step; the quotient bit takes its place.
		always_comb begin
			n_c = n_p;
			r_c = r_p;
			for (int k = 0; k < BITS_PER_STAGE; k++) begin
				if (s * BITS_PER_STAGE + k < NUM_BITS) begin
					r_c = {r_c[REM_BITS-2:0], n_c[NUM_BITS-1]};
					n_c = {n_c[NUM_BITS-2:0], 1'b0};
					if (r_c >= {1'b0, d_p}) begin
						r_c = r_c - {1'b0, d_p};
						n_c[0] = 1'b1;
					end
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[s+1] <= 1'b0;
			end else if (en) begin
				v_q[s+1] <= v_p;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				z_q[s+1] <= z_p;
				n_q[s+1] <= n_c;
				d_q[s+1] <= d_p;
				r_q[s+1] <= r_c;
			end
		end
	end

	assign out_valid = v_q[STAGES];
	assign out_quot  = n_q[STAGES];
	assign out_zero  = z_q[STAGES];
endmodule

// ===== tb/sv/half_face_transmissibility_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// half_face_transmissibility_tb
// Self-checking bench for the half-face transmissibility pipeline.
// ----------------------------------------------------------------------------
// Half-face beats are streamed into the block while both channels idle at
// random. Every accepted beat is run through an exact integer predictor of
// |d.(K n)| / (d.d) in Q24.24, and each result beat is compared field by
// field with the oldest prediction. Directed beats cover zero distance,
// saturation, sign of the owner flag and the field extremes. Random beats
// then mix well-scaled geometry with raw bit patterns.
module half_face_transmissibility_tb;
	import hft_pkg::*;

	localparam int COMP       = 21;
	localparam int NDIM       = 3;
	localparam int SETTLE     = 60;
	localparam int CYCLE_CAP  = 600000;
	localparam logic [47:0] TRANS_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0][VEC_BITS-1:0] perm;
		logic [VEC_BITS-1:0]      normal_vec;
		logic [VEC_BITS-1:0]      face_center;
		logic [VEC_BITS-1:0]      cell_center;
		logic                     is_first_cell;
	} face_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] half_trans;
		logic                zero_distance;
		logic                saturated;
	} trans_t;

	logic   clk;
	logic   arst_n;
	trans_t trans_q[$];
	int     mismatches;
	int     faces_sent;
	int     results_seen;
	int     saturated_seen;
	int     zero_seen;
	longint cycles;
	bit     send_idle_on;
	bit     recv_idle_on;

	hft_in_if  in_ch();
	hft_out_if out_ch();

	half_face_transmissibility i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Clock and cycle limit.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, trans_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Sign-extended component of a packed vector.
	function automatic longint vec_comp(logic [VEC_BITS-1:0] v, int idx);
		logic signed [COMP-1:0] s;
		s = v[idx*COMP +: COMP];
		return s;
	endfunction

	// Exact half transmissibility: 128-bit numerator, truncating division.
	function automatic trans_t predict_half_trans(face_t f);
		longint                kn[NDIM];
		longint                offs[NDIM];
		logic [63:0]           den;
		logic signed [127:0]   num;
		logic signed [127:0]   dw;
		logic signed [127:0]   kw;
		logic [127:0]          mag;
		logic [127:0]          quo;
		trans_t                t;
		den = 0;
		num = 0;
		for (int r = 0; r < NDIM; r++) begin
			kn[r] = 0;
			for (int c = 0; c < NDIM; c++)
				kn[r] += vec_comp(f.perm[c], r) * vec_comp(f.normal_vec, c);
			offs[r] = vec_comp(f.face_center, r) - vec_comp(f.cell_center, r);
			den += offs[r] * offs[r];
		end
		if (den == 0) begin
			t.half_trans    = '0;
			t.zero_distance = 1'b1;
			t.saturated     = 1'b0;
			return t;
		end
		for (int r = 0; r < NDIM; r++) begin
			dw = offs[r];
			kw = kn[r];
			num += dw * kw;
		end
		// The owner sign only flips the numerator; the magnitude drops it.
		mag = (num < 0) ? -num : num;
		mag = mag << (OUT_FRAC_BITS - FRAC_BITS);
		quo = mag / {64'b0, den};
		t.zero_distance = 1'b0;
		if (quo > {80'b0, TRANS_MAX}) begin
			t.half_trans = TRANS_MAX;
			t.saturated  = 1'b1;
		end else begin
			t.half_trans = quo[OUT_BITS-1:0];
			t.saturated  = 1'b0;
		end
		return t;
	endfunction

	// Gap length: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [COMP-1:0] q10(int value);
		return COMP'(value * 1024);
	endfunction

	function automatic logic [VEC_BITS-1:0] pack3(logic [COMP-1:0] x, logic [COMP-1:0] y,
		logic [COMP-1:0] z);
		return {z, y, x};
	endfunction

	// Component drawn from a mix of extremes, small values and raw bits.
	function automatic logic [COMP-1:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {1'b0, {(COMP-1){1'b1}}};
			2: return {1'b1, {(COMP-1){1'b0}}};
			3, 4: return COMP'($urandom);
			default: return COMP'($urandom_range(0, 8191) - 4096);
		endcase
	endfunction

	function automatic logic [VEC_BITS-1:0] rand_vec();
		return pack3(rand_comp(), rand_comp(), rand_comp());
	endfunction

	function automatic logic [VEC_BITS-1:0] raw_vec();
		return VEC_BITS'({$urandom, $urandom});
	endfunction

	// Receiver: ready toggles at random unless idling is switched off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (!recv_idle_on) begin
			out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= (pick_gap() == 0);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		trans_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (out_ch.saturated)
				saturated_seen++;
			if (out_ch.zero_distance)
				zero_seen++;
			if (trans_q.size() == 0) begin
				$error("result beat with no expectation waiting");
				mismatches++;
			end else begin
				want = trans_q.pop_front();
				if (out_ch.half_trans !== want.half_trans) begin
					$error("half_trans: expected %h, got %h", want.half_trans, out_ch.half_trans);
					mismatches++;
				end
				if (out_ch.zero_distance !== want.zero_distance) begin
					$error("zero_distance: expected %b, got %b", want.zero_distance,
						out_ch.zero_distance);
					mismatches++;
				end
				if (out_ch.saturated !== want.saturated) begin
					$error("saturated: expected %b, got %b", want.saturated, out_ch.saturated);
					mismatches++;
				end
			end
		end
	end

	// Send one half-face beat and record its prediction at acceptance.
	task automatic send_face(face_t f);
		int gap;
		in_ch.valid         <= 1'b1;
		in_ch.perm_col0     <= f.perm[0];
		in_ch.perm_col1     <= f.perm[1];
		in_ch.perm_col2     <= f.perm[2];
		in_ch.normal_vec    <= f.normal_vec;
		in_ch.face_center   <= f.face_center;
		in_ch.cell_center   <= f.cell_center;
		in_ch.is_first_cell <= f.is_first_cell;
		do
			@(posedge clk);
		while (!in_ch.ready);
		trans_q.push_back(predict_half_trans(f));
		faces_sent++;
		gap = send_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (trans_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic face_t unit_face(logic [VEC_BITS-1:0] d_face, logic first);
		face_t f;
		f.perm[0]       = pack3(q10(1), '0, '0);
		f.perm[1]       = pack3('0, q10(1), '0);
		f.perm[2]       = pack3('0, '0, q10(1));
		f.normal_vec    = pack3(q10(1), '0, '0);
		f.face_center   = d_face;
		f.cell_center   = '0;
		f.is_first_cell = first;
		return f;
	endfunction

	// Directed: unit geometry, both owner signs, zero distance, extremes.
	task automatic test_directed();
		face_t f;
		send_face(unit_face(pack3(q10(1), '0, '0), 1'b1));
		send_face(unit_face(pack3(q10(1), '0, '0), 1'b0));
		send_face(unit_face(pack3(q10(-1), '0, '0), 1'b1));
		send_face(unit_face(pack3(q10(3), '0, '0), 1'b1));
		send_face(unit_face(pack3(q10(3), q10(-2), 21'd7), 1'b0));
		// Truncation of a non-terminating quotient.
		send_face(unit_face(pack3(21'd3, '0, '0), 1'b1));
		// Zero distance, with coincident non-zero centroids too.
		f = unit_face('0, 1'b1);
		send_face(f);
		f.face_center = pack3(q10(5), q10(-5), 21'h1FFFFF);
		f.cell_center = f.face_center;
		send_face(f);
		// Tiny distance with a big tensor saturates.
		f = unit_face(pack3(21'd1, '0, '0), 1'b1);
		f.perm[0] = pack3({1'b0, {20{1'b1}}}, '0, '0);
		f.normal_vec = pack3({1'b0, {20{1'b1}}}, '0, '0);
		send_face(f);
		// All fields at their largest and smallest patterns.
		f.perm = {3{{VEC_BITS{1'b1}}}};
		f.normal_vec = {VEC_BITS{1'b1}};
		f.face_center = {VEC_BITS{1'b1}};
		f.cell_center = '0;
		send_face(f);
		f.perm = {3{pack3({1'b1, 20'b0}, {1'b1, 20'b0}, {1'b1, 20'b0})}};
		f.normal_vec = pack3({1'b1, 20'b0}, {1'b1, 20'b0}, {1'b1, 20'b0});
		f.face_center = pack3({1'b1, 20'b0}, {1'b1, 20'b0}, {1'b1, 20'b0});
		f.cell_center = pack3({1'b0, {20{1'b1}}}, {1'b0, {20{1'b1}}}, {1'b0, {20{1'b1}}});
		send_face(f);
		f.perm = {3{pack3({1'b0, {20{1'b1}}}, {1'b0, {20{1'b1}}}, {1'b0, {20{1'b1}}})}};
		f.normal_vec = pack3({1'b0, {20{1'b1}}}, {1'b0, {20{1'b1}}}, {1'b0, {20{1'b1}}});
		f.is_first_cell = 1'b0;
		send_face(f);
		// Zero tensor with a real distance gives exactly zero.
		f = unit_face(pack3(q10(2), q10(2), '0), 1'b1);
		f.perm = '0;
		send_face(f);
	endtask

	// Random beats: mostly structured components, some raw bit patterns.
	task automatic test_random(int count);
		face_t f;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				f.perm        = {raw_vec(), raw_vec(), raw_vec()};
				f.normal_vec  = raw_vec();
				f.face_center = raw_vec();
				f.cell_center = raw_vec();
			end else begin
				f.perm        = {rand_vec(), rand_vec(), rand_vec()};
				f.normal_vec  = rand_vec();
				f.face_center = rand_vec();
				f.cell_center = ($urandom_range(0, 19) == 0) ? f.face_center : rand_vec();
			end
			f.is_first_cell = 1'($urandom);
			send_face(f);
		end
	endtask

	// Sender holds off until the pipeline has emptied, then resumes.
	task automatic test_drain_pause();
		test_random(30);
		in_ch.valid <= 1'b0;
		wait_drained();
		@(posedge clk);
		test_random(30);
	endtask

	// Full rate on both sides.
	task automatic test_streaming();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		test_random(200);
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	initial begin
		mismatches     = 0;
		faces_sent     = 0;
		results_seen   = 0;
		saturated_seen = 0;
		zero_seen      = 0;
		cycles         = 0;
		send_idle_on   = 1'b1;
		recv_idle_on   = 1'b1;
		arst_n         = 1'b0;
		in_ch.valid         <= 1'b0;
		in_ch.perm_col0     <= '0;
		in_ch.perm_col1     <= '0;
		in_ch.perm_col2     <= '0;
		in_ch.normal_vec    <= '0;
		in_ch.face_center   <= '0;
		in_ch.cell_center   <= '0;
		in_ch.is_first_cell <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(700);
		test_drain_pause();
		test_streaming();
		test_random(760);

		in_ch.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("%0d half-faces sent, %0d results checked (%0d saturated, %0d zero distance)",
			faces_sent, results_seen, saturated_seen, zero_seen);
		$display("directed corners, random geometry, a drain pause and full-rate streaming");
		if (mismatches == 0 && trans_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, trans_q.size());
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== half_face_transmissibility.f =====
rtl/core/hft_pkg.sv
rtl/core/hft_if.sv
rtl/core/hft_divider.sv
rtl/core/half_face_transmissibility.sv
tb/sv/half_face_transmissibility_tb.sv
